// File: src/lzwd_pkg.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor package
// Widths, limits and result status codes shared by the interfaces and the core.
// ----------------------------------------------------------------------------
package lzwd_pkg;

  // Window geometry
  localparam int WINDOW_BYTES = 4096;
  localparam int WIN_ADDR_W   = $clog2(WINDOW_BYTES);

  // Output counting
  localparam int                 COUNT_W          = 17;
  localparam logic [COUNT_W-1:0] MAX_CHUNK_OUTPUT = 17'd65536;

  // Match word fields
  localparam int LEN_W      = 4;
  localparam int COPY_CNT_W = 5;
  localparam logic [COPY_CNT_W-1:0] LEN_BIAS = 5'd2;

  // Configuration port
  localparam int CFG_DATA_W = 32;
  localparam int CFG_ADDR_W = 2;
  localparam logic [CFG_ADDR_W-1:0] OUTPUT_LIMIT_ADDR = 2'd0;

  // Result status codes
  localparam int              STATUS_W        = 2;
  localparam logic [STATUS_W-1:0] ST_DATA      = 2'd0;
  localparam logic [STATUS_W-1:0] ST_END       = 2'd1;
  localparam logic [STATUS_W-1:0] ST_TRUNCATED = 2'd2;
  localparam logic [STATUS_W-1:0] ST_OVERRUN   = 2'd3;

endpackage

// File: src/lzwd_ifs.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor channel interfaces
// Valid/ready channels for compressed input bytes and decoded results.
// ----------------------------------------------------------------------------
interface lzwd_in_if import lzwd_pkg::*;;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  logic       first_of_chunk;
  logic       last_of_chunk;

  modport source (output valid, data_byte, first_of_chunk, last_of_chunk, input ready);
  modport sink   (input valid, data_byte, first_of_chunk, last_of_chunk, output ready);
endinterface

interface lzwd_out_if import lzwd_pkg::*;;
  logic                valid;
  logic                ready;
  logic [7:0]          out_byte;
  logic [STATUS_W-1:0] status;
  logic                last_of_run;

  modport source (output valid, out_byte, status, last_of_run, input ready);
  modport sink   (input valid, out_byte, status, last_of_run, output ready);
endinterface

// File: src/lz77_window_decompressor_top.sv
// ----------------------------------------------------------------------------
// LZ77 window decompressor
// Decodes tag, literal and match bytes against a 4096-byte history window.
// ----------------------------------------------------------------------------
// A tag, literal or status result is registered in the output register in the cycle
// after its input transaction; each match byte passes a window read state, then a
// write state that waits for output space. Tag, literal and status bytes are taken
// back to back while the output is free; a match holds the input until its last byte.
// Reset: synchronous, active low; afterwards a clearing pass writes zero to
// all 4096 window entries, with no input taken meanwhile.
module lz77_window_decompressor_top import lzwd_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  lzwd_in_if.sink               in_ch,
  lzwd_out_if.source            out_ch,
  input  logic                  cfg_psel,
  input  logic                  cfg_penable,
  input  logic                  cfg_pwrite,
  input  logic [CFG_ADDR_W-1:0] cfg_paddr,
  input  logic [CFG_DATA_W-1:0] cfg_pwdata,
  output logic [CFG_DATA_W-1:0] cfg_prdata,
  output logic                  cfg_pready
);

  // Sequencer state codes
  localparam logic [1:0] S_CLEAR   = 2'd0;
  localparam logic [1:0] S_IDLE    = 2'd1;
  localparam logic [1:0] S_COPY_RD = 2'd2;
  localparam logic [1:0] S_COPY_WR = 2'd3;

  localparam logic [WIN_ADDR_W-1:0] WIN_LAST = WIN_ADDR_W'(WINDOW_BYTES - 1);

  logic [1:0]            state_r, state_nxt;
  logic [WIN_ADDR_W-1:0] clr_addr_r;
  logic [COUNT_W-1:0]    limit_r;

  // Decoder state
  logic [WIN_ADDR_W-1:0] wpos_r, wpos_nxt;
  logic [7:0]            flags_r, flags_nxt;
  logic [3:0]            left_r, left_nxt;
  logic                  phase_r, phase_nxt;
  logic [7:0]            low_r, low_nxt;
  logic [COUNT_W-1:0]    prod_r, prod_nxt;
  logic                  fin_r, fin_nxt;

  // Copy engine
  logic [WIN_ADDR_W-1:0] copy_off_r, copy_off_nxt;
  logic [COPY_CNT_W-1:0] copy_left_r, copy_left_nxt;

  // Output register
  logic                out_valid_r, out_valid_nxt;
  logic [7:0]          out_byte_r, out_byte_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;
  logic                out_last_r, out_last_nxt;

  // Window memory
  logic [7:0]            win_mem [WINDOW_BYTES];
  logic [7:0]            rd_data_r;
  logic                  wr_en;
  logic [WIN_ADDR_W-1:0] wr_addr;
  logic [7:0]            wr_data;

  // Decode helpers
  logic                  in_acc;
  logic                  out_free;
  logic [COUNT_W-1:0]    lim;
  logic [WIN_ADDR_W-1:0] e_wpos;
  logic [7:0]            e_flags;
  logic [3:0]            e_left;
  logic                  e_phase;
  logic [7:0]            e_low;
  logic [COUNT_W-1:0]    e_prod;
  logic                  e_fin;
  logic [WIN_ADDR_W-1:0] m_off;
  logic [COPY_CNT_W-1:0] m_cnt;
  logic [COUNT_W:0]      m_total;

  // Configuration register
  assign cfg_pready = 1'b1;
  assign cfg_prdata = (cfg_paddr == OUTPUT_LIMIT_ADDR) ? CFG_DATA_W'(limit_r) : '0;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      limit_r <= MAX_CHUNK_OUTPUT;
    end else if (cfg_psel && cfg_penable && cfg_pwrite && cfg_pready) begin
      limit_r <= cfg_pwdata[COUNT_W-1:0];
    end
  end

  assign lim = (limit_r > MAX_CHUNK_OUTPUT) ? MAX_CHUNK_OUTPUT : limit_r;

  // Handshakes
  assign out_free     = !out_valid_r || out_ch.ready;
  assign in_ch.ready  = (state_r == S_IDLE) && out_free;
  assign in_acc       = in_ch.valid && in_ch.ready;
  assign out_ch.valid       = out_valid_r;
  assign out_ch.out_byte    = out_byte_r;
  assign out_ch.status      = out_status_r;
  assign out_ch.last_of_run = out_last_r;

  // Apply a chunk restart ahead of the byte itself
  always_comb begin
    if (in_ch.first_of_chunk) begin
      e_wpos  = WIN_ADDR_W'(1);
      e_flags = '0;
      e_left  = '0;
      e_phase = 1'b0;
      e_low   = '0;
      e_prod  = '0;
      e_fin   = 1'b0;
    end else begin
      e_wpos  = wpos_r;
      e_flags = flags_r;
      e_left  = left_r;
      e_phase = phase_r;
      e_low   = low_r;
      e_prod  = prod_r;
      e_fin   = fin_r;
    end
  end

  // Match word fields: offset is the upper 12 bits, length the low 4 plus bias
  assign m_off   = {in_ch.data_byte, e_low[7:LEN_W]};
  assign m_cnt   = COPY_CNT_W'(e_low[LEN_W-1:0]) + LEN_BIAS;
  assign m_total = {1'b0, e_prod} + (COUNT_W+1)'(m_cnt);

  // Sequencer and decoder
  always_comb begin
    state_nxt      = state_r;
    wpos_nxt       = wpos_r;
    flags_nxt      = flags_r;
    left_nxt       = left_r;
    phase_nxt      = phase_r;
    low_nxt        = low_r;
    prod_nxt       = prod_r;
    fin_nxt        = fin_r;
    copy_off_nxt   = copy_off_r;
    copy_left_nxt  = copy_left_r;
    out_valid_nxt  = out_valid_r && !out_ch.ready;
    out_byte_nxt   = out_byte_r;
    out_status_nxt = out_status_r;
    out_last_nxt   = out_last_r;
    wr_en          = 1'b0;
    wr_addr        = wpos_r;
    wr_data        = in_ch.data_byte;

    case (state_r)
      S_CLEAR: begin
        // Sweep zero through the window
        wr_en   = 1'b1;
        wr_addr = clr_addr_r;
        wr_data = '0;
        if (clr_addr_r == WIN_LAST) begin
          state_nxt = S_IDLE;
        end
      end

      S_IDLE: begin
        if (in_acc) begin
          wpos_nxt  = e_wpos;
          flags_nxt = e_flags;
          left_nxt  = e_left;
          phase_nxt = e_phase;
          low_nxt   = e_low;
          prod_nxt  = e_prod;
          fin_nxt   = e_fin;
          out_byte_nxt   = '0;
          out_last_nxt   = 1'b1;
          out_status_nxt = ST_TRUNCATED;
          if (!e_fin) begin
            if (e_left == '0) begin
              // Tag byte: load eight fresh flags
              flags_nxt = in_ch.data_byte;
              left_nxt  = 4'd8;
              if (in_ch.last_of_chunk) begin
                out_valid_nxt = 1'b1;
                fin_nxt       = 1'b1;
              end
            end else if (!e_flags[0]) begin
              // Literal byte
              if (e_prod >= lim) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_OVERRUN;
                fin_nxt        = 1'b1;
              end else if (in_ch.last_of_chunk) begin
                out_valid_nxt = 1'b1;
                fin_nxt       = 1'b1;
              end else begin
                wr_en          = 1'b1;
                wr_addr        = e_wpos;
                wpos_nxt       = e_wpos + 1'b1;
                prod_nxt       = e_prod + 1'b1;
                out_valid_nxt  = 1'b1;
                out_byte_nxt   = in_ch.data_byte;
                out_status_nxt = ST_DATA;
                flags_nxt      = {1'b0, e_flags[7:1]};
                left_nxt       = e_left - 1'b1;
              end
            end else if (!e_phase) begin
              // Low byte of a match word
              low_nxt   = in_ch.data_byte;
              phase_nxt = 1'b1;
              if (in_ch.last_of_chunk) begin
                out_valid_nxt = 1'b1;
                fin_nxt       = 1'b1;
              end
            end else begin
              // High byte of a match word
              phase_nxt = 1'b0;
              if (m_off == '0) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_END;
                fin_nxt        = 1'b1;
              end else if (m_total > (COUNT_W+1)'(lim)) begin
                out_valid_nxt  = 1'b1;
                out_status_nxt = ST_OVERRUN;
                fin_nxt        = 1'b1;
              end else if (in_ch.last_of_chunk) begin
                out_valid_nxt = 1'b1;
                fin_nxt       = 1'b1;
              end else begin
                copy_off_nxt  = m_off;
                copy_left_nxt = m_cnt;
                prod_nxt      = m_total[COUNT_W-1:0];
                flags_nxt     = {1'b0, e_flags[7:1]};
                left_nxt      = e_left - 1'b1;
                state_nxt     = S_COPY_RD;
              end
            end
          end
        end
      end

      S_COPY_RD: begin
        // Window read is in flight
        state_nxt = S_COPY_WR;
      end

      S_COPY_WR: begin
        // Emit the fetched byte and append it to the window
        if (out_free) begin
          wr_en          = 1'b1;
          wr_addr        = wpos_r;
          wr_data        = rd_data_r;
          wpos_nxt       = wpos_r + 1'b1;
          copy_off_nxt   = copy_off_r + 1'b1;
          copy_left_nxt  = copy_left_r - 1'b1;
          out_valid_nxt  = 1'b1;
          out_byte_nxt   = rd_data_r;
          out_status_nxt = ST_DATA;
          out_last_nxt   = (copy_left_r == COPY_CNT_W'(1));
          state_nxt      = (copy_left_r == COPY_CNT_W'(1)) ? S_IDLE : S_COPY_RD;
        end
      end

      default: begin
        state_nxt = S_CLEAR;
      end
    endcase
  end

  // Window memory: one write port, one registered read port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      win_mem[wr_addr] <= wr_data;
    end
    rd_data_r <= win_mem[copy_off_r];
  end

  // Control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      clr_addr_r  <= '0;
      wpos_r      <= WIN_ADDR_W'(1);
      flags_r     <= '0;
      left_r      <= '0;
      phase_r     <= 1'b0;
      low_r       <= '0;
      prod_r      <= '0;
      fin_r       <= 1'b0;
      copy_left_r <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_addr_r  <= (state_r == S_CLEAR) ? clr_addr_r + 1'b1 : clr_addr_r;
      wpos_r      <= wpos_nxt;
      flags_r     <= flags_nxt;
      left_r      <= left_nxt;
      phase_r     <= phase_nxt;
      low_r       <= low_nxt;
      prod_r      <= prod_nxt;
      fin_r       <= fin_nxt;
      copy_left_r <= copy_left_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    copy_off_r   <= copy_off_nxt;
    out_byte_r   <= out_byte_nxt;
    out_status_r <= out_status_nxt;
    out_last_r   <= out_last_nxt;
  end

endmodule
